@@ design/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, types and state codes for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 16;
    localparam int DATA_W     = 16;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W     = $clog2(ENTRIES + 1);
    localparam int CMPW       = (USED_W > CAP_W) ? USED_W : CAP_W;

    localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] CAP_ADDR = 3'd0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [DATA_W-1:0]     t_data;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // Running result of the scan, fed back to the compare unit.
    typedef struct packed {
        logic   match_found;
        logic   free_found;
        logic   victim_found;
        t_count victim_count;
        t_idx   victim_rank;
    } t_scan;

    // Which trackers take the entry under the scan pointer.
    typedef struct packed {
        logic match;
        logic free;
        logic victim;
    } t_take;

endpackage

@@ design/lfu_cmp.sv @@
// ----------------------------------------------------------------------------
// lfu_cmp
// Compare unit shared by all scan steps: key match, free slot and victim order.
// ----------------------------------------------------------------------------
module lfu_cmp (
    input  logic           i_valid,
    input  lfu_pkg::t_key   i_entry_key,
    input  lfu_pkg::t_count i_entry_count,
    input  lfu_pkg::t_idx   i_entry_rank,
    input  lfu_pkg::t_key   i_search_key,
    input  lfu_pkg::t_scan  i_scan,
    output lfu_pkg::t_take  o_take
);
    import lfu_pkg::*;

    logic lower_count;
    logic same_count;
    logic older;

    assign lower_count = i_entry_count < i_scan.victim_count;
    assign same_count  = i_entry_count == i_scan.victim_count;
    assign older       = i_entry_rank > i_scan.victim_rank;

    always_comb begin
        o_take.match  = i_valid && (i_entry_key == i_search_key) && !i_scan.match_found;
        o_take.free   = !i_valid && !i_scan.free_found;
        o_take.victim = i_valid && (!i_scan.victim_found || lower_count ||
                                    (same_count && older));
    end

endmodule

@@ design/lfu_cache_replacement.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_replacement
// LFU key-value cache with LRU tie-break; one entry compared per cycle.
// ----------------------------------------------------------------------------
// Each item is scanned over every entry once through the single compare unit and
// then applied in an update step; no new item is taken until the update is done,
// and the update waits while the output register holds an unaccepted result.
// Reset (synchronous, active low): all entries invalid, capacity 16.
// A result may wait in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module lfu_cache_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[0], key[16:1], value[32:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hit[0], read_value[16:1], evicted[17],
                                        // evicted_key[33:18]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfu_pkg::*;

    t_state r_state, n_state;
    logic [CAP_W-1:0] r_capacity;

    logic   r_valid [ENTRIES];
    t_key   r_key   [ENTRIES];
    t_data  r_data  [ENTRIES];
    t_count r_count [ENTRIES];
    t_idx   r_rank  [ENTRIES];
    t_idx   n_rank  [ENTRIES];

    logic  r_cmd;
    t_key  r_skey;
    t_data r_sval;
    t_idx  r_idx;

    t_scan             r_scan;
    t_idx              r_midx, r_mrank, r_fidx, r_vidx;
    t_data             r_mdata;
    t_count            r_mcount;
    t_key              r_vkey;
    logic [USED_W-1:0] r_used;

    t_take take;

    logic              r_out_valid;
    logic              r_out_hit;
    t_data             r_out_rdata;
    logic              r_out_evicted;
    t_key              r_out_ekey;

    logic              in_fire, upd_fire, scan_last;
    logic [CMPW-1:0]   cap_eff;
    logic              use_free, do_ins, evict;
    t_idx              slot;

    // APB
    assign pready = 1'b1;
    assign prdata = {{(32-CAP_W){1'b0}}, r_capacity};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr == CAP_ADDR)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // Shared compare unit
    lfu_cmp u_cmp (
        .i_valid       (r_valid[r_idx]),
        .i_entry_key   (r_key[r_idx]),
        .i_entry_count (r_count[r_idx]),
        .i_entry_rank  (r_rank[r_idx]),
        .i_search_key  (r_skey),
        .i_scan        (r_scan),
        .o_take        (take)
    );

    // Sequencer
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign scan_last     = (r_idx == IDX_W'(ENTRIES - 1));
    assign upd_fire      = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_idx  <= '0;
            r_used <= '0;
        end else if (in_fire) begin
            r_scan <= '0;
            r_idx  <= '0;
            r_used <= '0;
        end else if (r_state == S_SCAN) begin
            if (!scan_last) r_idx <= r_idx + 1'b1;
            if (r_valid[r_idx]) r_used <= r_used + 1'b1;
            if (take.match) r_scan.match_found <= 1'b1;
            if (take.free) r_scan.free_found <= 1'b1;
            if (take.victim) begin
                r_scan.victim_found <= 1'b1;
                r_scan.victim_count <= r_count[r_idx];
                r_scan.victim_rank  <= r_rank[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= s_axis_tdata[0];
            r_skey <= s_axis_tdata[16:1];
            r_sval <= s_axis_tdata[32:17];
        end
        if (r_state == S_SCAN) begin
            if (take.match) begin
                r_midx   <= r_idx;
                r_mrank  <= r_rank[r_idx];
                r_mdata  <= r_data[r_idx];
                r_mcount <= r_count[r_idx];
            end
            if (take.free) r_fidx <= r_idx;
            if (take.victim) begin
                r_vidx <= r_idx;
                r_vkey <= r_key[r_idx];
            end
        end
    end

    // Update decision
    assign cap_eff  = (CMPW'(r_capacity) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES)
                                                           : CMPW'(r_capacity);
    assign use_free = (CMPW'(r_used) < cap_eff) && r_scan.free_found;
    assign do_ins   = !r_scan.match_found && (r_cmd == CMD_PUT) && (cap_eff != '0) &&
                      (use_free || r_scan.victim_found);
    assign evict    = do_ins && !use_free;
    assign slot     = r_scan.match_found ? r_midx : (use_free ? r_fidx : r_vidx);

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            n_rank[j] = r_rank[j];
            if (r_scan.match_found) begin
                if (IDX_W'(j) == r_midx) begin
                    n_rank[j] = '0;
                end else if (r_valid[j] && (r_rank[j] < r_mrank)) begin
                    n_rank[j] = r_rank[j] + 1'b1;
                end
            end else if (do_ins) begin
                if (IDX_W'(j) == slot) begin
                    n_rank[j] = '0;
                end else if (r_valid[j] && (!evict || (r_rank[j] < r_scan.victim_rank))) begin
                    n_rank[j] = r_rank[j] + 1'b1;
                end
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ENTRIES; j++) r_valid[j] <= 1'b0;
        end else if (upd_fire && do_ins) begin
            r_valid[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            for (int j = 0; j < ENTRIES; j++) r_rank[j] <= n_rank[j];
            if (r_scan.match_found) begin
                if (r_cmd == CMD_PUT) r_data[slot] <= r_sval;
                if (r_mcount != COUNT_MAX) r_count[slot] <= r_mcount + 1'b1;
            end else if (do_ins) begin
                r_key[slot]   <= r_skey;
                r_data[slot]  <= r_sval;
                r_count[slot] <= t_count'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_hit     <= r_scan.match_found;
            r_out_rdata   <= (r_scan.match_found && (r_cmd == CMD_GET)) ? r_mdata : '0;
            r_out_evicted <= evict;
            r_out_ekey    <= evict ? r_vkey : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_ekey, r_out_evicted, r_out_rdata, r_out_hit};

    // Checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted beat did not start a scan");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evicted))
        else $error("result shows both hit and eviction");

    a_evict_valid_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_fire && evict) |-> r_valid[slot])
        else $error("eviction picked an empty slot");

endmodule
